### src/cmfr_pkg.sv
// Package: shared types, codes and verdict helper for the cross-link match filter.
`timescale 1ns / 1ps
`default_nettype none

package cmfr_pkg;

  localparam int unsigned LenW   = 7;
  localparam int unsigned SiteW  = 6;
  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 5;

  typedef enum logic [0:0] {
    CMD_HEADER  = 1'b0,
    CMD_RESIDUE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    LINK_NONE   = 2'd0,
    LINK_SINGLE = 2'd1,
    LINK_LOOP   = 2'd2,
    LINK_PAIR   = 2'd3
  } link_type_t;

  typedef enum logic [2:0] {
    RSN_PASS      = 3'd0,
    RSN_CTERM     = 3'd1,
    RSN_EVALUE    = 3'd2,
    RSN_SCORE     = 3'd3,
    RSN_LENGTH    = 3'd4,
    RSN_RATIO     = 3'd5,
    RSN_ALPHA_RUN = 3'd6,
    RSN_BETA_RUN  = 3'd7
  } reason_t;

  typedef enum logic [2:0] {
    REG_EVALUE_MAX   = 3'd0,
    REG_SCORE_MIN    = 3'd1,
    REG_MIN_PEP_LEN  = 3'd2,
    REG_RATIO_MIN    = 3'd3,
    REG_CONF_LEVEL   = 3'd4,
    REG_MIN_RUN      = 3'd5,
    REG_ALLOW_CTERM  = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_index_t;

  // Site sits on the last residue; an empty peptide never matches.
  function automatic logic at_cterm(input logic [SiteW-1:0] site,
                                    input logic [LenW-1:0]  len);
    at_cterm = (len != '0) && ({1'b0, site} == (len - LenW'(1)));
  endfunction

  // Header verdict stands first, then alpha run, then beta run.
  function automatic reason_t final_reason(input reason_t         pending,
                                           input logic [LenW-1:0] a_run,
                                           input logic [LenW-1:0] b_run,
                                           input logic            pair,
                                           input logic [LenW-1:0] min_run);
    reason_t r;
    r = pending;
    if (r == RSN_PASS && a_run < min_run) r = RSN_ALPHA_RUN;
    if (r == RSN_PASS && pair && b_run < min_run) r = RSN_BETA_RUN;
    final_reason = r;
  endfunction

endpackage

`default_nettype wire

### src/crosslink_match_result_filter_unit.sv
// Top level: cross-link match filter with APB-style registers and registered verdict.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel (in_valid/in_ready): a header transaction (command 0) opens a match,
//   then one residue transaction (command 1) per residue, alpha residues first, then
//   beta residues when is_pair is set. Stray residues with no open match are dropped.
//   Result channel (out_valid/out_ready): one verdict per finished match, carrying accepted,
//   reject_reason and the longest confident run of each peptide.
//   Register port: APB-style, register n at byte address 4*n, pready tied high.
//   Registers are to be written only while no match is open.
// Throughput
//   One transaction per clock while in_ready is high. The verdict enters the output
//   register at the edge that takes the header (no residues expected) or the last residue.
//   All checks, including the 16x32 ratio product, sit ahead of the match and output registers.
// Reset
//   rst_n clears the output valid and all match state and loads register defaults:
//   e-value max all ones, score min most negative, C-terminal links allowed, rest 0.
// Stall
//   While a verdict waits and out_ready is low, in_ready drops; nothing is lost.
//   When out_ready is high, a new transaction is taken in the same cycle.
module crosslink_match_result_filter_unit #(
  parameter int unsigned MAX_PEPTIDE_LEN = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [1:0]                    in_link_type,
  input  wire logic [cmfr_pkg::SiteW-1:0]    in_alpha_site,
  input  wire logic [cmfr_pkg::SiteW-1:0]    in_beta_site,
  input  wire logic [cmfr_pkg::LenW-1:0]     in_alpha_length,
  input  wire logic [cmfr_pkg::LenW-1:0]     in_beta_length,
  input  wire logic                          in_is_pair,
  input  wire logic [31:0]                   in_evalue,
  input  wire logic signed [31:0]            in_score,
  input  wire logic [31:0]                   in_matched_intensity,
  input  wire logic [31:0]                   in_unmatched_intensity,
  input  wire logic [7:0]                    in_residue_confidence,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_accepted,
  output logic [2:0]                         out_reject_reason,
  output logic [cmfr_pkg::LenW-1:0]          out_alpha_longest_run,
  output logic [cmfr_pkg::LenW-1:0]          out_beta_longest_run,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cmfr_pkg::AddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import cmfr_pkg::*;

  // Saturation limit; lengths are 7 bits so a limit from 127 to 255 never bites.
  localparam logic [CountW-1:0] MaxLen = CountW'(MAX_PEPTIDE_LEN);

  // ---------------------------------------------------------------- registers
  logic [31:0]       evalue_max_r;
  logic [31:0]       score_min_r;
  logic [LenW-1:0]   min_pep_len_r;
  logic [15:0]       ratio_min_r;
  logic [7:0]        conf_level_r;
  logic [LenW-1:0]   min_run_r;
  logic              allow_cterm_r;

  reg_index_t        reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evalue_max_r  <= '1;
      score_min_r   <= 32'h8000_0000;
      min_pep_len_r <= '0;
      ratio_min_r   <= '0;
      conf_level_r  <= '0;
      min_run_r     <= '0;
      allow_cterm_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_EVALUE_MAX:  evalue_max_r  <= pwdata;
        REG_SCORE_MIN:   score_min_r   <= pwdata;
        REG_MIN_PEP_LEN: min_pep_len_r <= pwdata[LenW-1:0];
        REG_RATIO_MIN:   ratio_min_r   <= pwdata[15:0];
        REG_CONF_LEVEL:  conf_level_r  <= pwdata[7:0];
        REG_MIN_RUN:     min_run_r     <= pwdata[LenW-1:0];
        REG_ALLOW_CTERM: allow_cterm_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EVALUE_MAX:  prdata = evalue_max_r;
      REG_SCORE_MIN:   prdata = score_min_r;
      REG_MIN_PEP_LEN: prdata = {{(32-LenW){1'b0}}, min_pep_len_r};
      REG_RATIO_MIN:   prdata = {16'd0, ratio_min_r};
      REG_CONF_LEVEL:  prdata = {24'd0, conf_level_r};
      REG_MIN_RUN:     prdata = {{(32-LenW){1'b0}}, min_run_r};
      REG_ALLOW_CTERM: prdata = {31'd0, allow_cterm_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- match state
  reason_t           pending_r,   pending_nxt;
  logic [LenW-1:0]   alpha_len_r, alpha_len_nxt;
  logic              pair_r,      pair_nxt;
  logic [CountW-1:0] expected_r,  expected_nxt;
  logic [CountW-1:0] count_r,     count_nxt;
  logic [LenW-1:0]   cur_run_r,   cur_run_nxt;
  logic [LenW-1:0]   long_run_r,  long_run_nxt;
  logic [LenW-1:0]   alpha_run_r, alpha_run_nxt;

  // result register
  logic              out_valid_r,  out_valid_nxt;
  reason_t           out_reason_r, out_reason_nxt;
  logic [LenW-1:0]   out_arun_r,   out_arun_nxt;
  logic [LenW-1:0]   out_brun_r,   out_brun_nxt;

  logic in_fire;
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------- header checks
  logic [LenW-1:0]   alen_sat, blen_sat;
  logic              cterm_hit;
  logic [47:0]       ratio_rhs;
  logic [47:0]       ratio_lhs;
  reason_t           hdr_reason;
  logic [CountW-1:0] hdr_expected;

  assign alen_sat = ({1'b0, in_alpha_length} > MaxLen) ? MaxLen[LenW-1:0] : in_alpha_length;
  assign blen_sat = ({1'b0, in_beta_length}  > MaxLen) ? MaxLen[LenW-1:0] : in_beta_length;

  always_comb begin
    cterm_hit = 1'b0;
    if (!allow_cterm_r) begin
      case (link_type_t'(in_link_type))
        LINK_SINGLE: cterm_hit = at_cterm(in_alpha_site, alen_sat);
        LINK_LOOP:   cterm_hit = at_cterm(in_alpha_site, alen_sat)
                              || at_cterm(in_beta_site, alen_sat);
        LINK_PAIR:   cterm_hit = at_cterm(in_alpha_site, alen_sat)
                              || at_cterm(in_beta_site, blen_sat);
        default:     cterm_hit = 1'b0;
      endcase
    end
  end

  // matched*256 against ratio*unmatched, both as 48-bit unsigned
  assign ratio_lhs = {8'd0, in_matched_intensity, 8'd0};
  assign ratio_rhs = 48'(ratio_min_r) * 48'(in_unmatched_intensity);

  always_comb begin
    if (cterm_hit)
      hdr_reason = RSN_CTERM;
    else if (in_evalue > evalue_max_r)
      hdr_reason = RSN_EVALUE;
    else if (in_score < $signed(score_min_r))
      hdr_reason = RSN_SCORE;
    else if (alen_sat < min_pep_len_r || (in_is_pair && blen_sat < min_pep_len_r))
      hdr_reason = RSN_LENGTH;
    else if (in_unmatched_intensity != '0 && ratio_lhs < ratio_rhs)
      hdr_reason = RSN_RATIO;
    else
      hdr_reason = RSN_PASS;
  end

  assign hdr_expected = CountW'(alen_sat) + (in_is_pair ? CountW'(blen_sat) : '0);

  // ---------------------------------------------------------------- residue step
  logic              conf_ok;
  logic [LenW-1:0]   run_inc;
  logic [LenW-1:0]   cur_step, long_step;
  logic [CountW-1:0] count_inc;
  logic              alpha_end;

  assign conf_ok   = in_residue_confidence >= conf_level_r;
  assign run_inc   = cur_run_r + LenW'(1);
  assign cur_step  = conf_ok ? run_inc : '0;
  assign long_step = (conf_ok && run_inc > long_run_r) ? run_inc : long_run_r;
  assign count_inc = count_r + CountW'(1);
  assign alpha_end = count_inc == CountW'(alpha_len_r);

  always_comb begin
    pending_nxt    = pending_r;
    alpha_len_nxt  = alpha_len_r;
    pair_nxt       = pair_r;
    expected_nxt   = expected_r;
    count_nxt      = count_r;
    cur_run_nxt    = cur_run_r;
    long_run_nxt   = long_run_r;
    alpha_run_nxt  = alpha_run_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_reason_nxt = out_reason_r;
    out_arun_nxt   = out_arun_r;
    out_brun_nxt   = out_brun_r;

    if (in_fire) begin
      if (command_t'(in_command) == CMD_HEADER) begin
        pending_nxt   = hdr_reason;
        alpha_len_nxt = alen_sat;
        pair_nxt      = in_is_pair;
        expected_nxt  = hdr_expected;
        count_nxt     = '0;
        cur_run_nxt   = '0;
        long_run_nxt  = '0;
        alpha_run_nxt = '0;
        if (hdr_expected == '0) begin
          // nothing to wait for: verdict now, both runs zero
          out_valid_nxt  = 1'b1;
          out_reason_nxt = final_reason(hdr_reason, '0, '0, in_is_pair, min_run_r);
          out_arun_nxt   = '0;
          out_brun_nxt   = '0;
        end
      end else if (expected_r != '0) begin
        count_nxt     = count_inc;
        cur_run_nxt   = alpha_end ? '0 : cur_step;
        long_run_nxt  = alpha_end ? '0 : long_step;
        alpha_run_nxt = alpha_end ? long_step : alpha_run_r;
        if (count_inc >= expected_r) begin
          out_valid_nxt  = 1'b1;
          out_arun_nxt   = alpha_run_nxt;
          out_brun_nxt   = pair_r ? long_run_nxt : '0;
          out_reason_nxt = final_reason(pending_r, alpha_run_nxt,
                                        pair_r ? long_run_nxt : '0, pair_r, min_run_r);
          expected_nxt   = '0;
          count_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= RSN_PASS;
      alpha_len_r <= '0;
      pair_r      <= 1'b0;
      expected_r  <= '0;
      count_r     <= '0;
      cur_run_r   <= '0;
      long_run_r  <= '0;
      alpha_run_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      alpha_len_r <= alpha_len_nxt;
      pair_r      <= pair_nxt;
      expected_r  <= expected_nxt;
      count_r     <= count_nxt;
      cur_run_r   <= cur_run_nxt;
      long_run_r  <= long_run_nxt;
      alpha_run_r <= alpha_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // verdict payload, no reset needed
  always_ff @(posedge clk) begin
    out_reason_r <= out_reason_nxt;
    out_arun_r   <= out_arun_nxt;
    out_brun_r   <= out_brun_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = (out_reason_r == RSN_PASS);
  assign out_reject_reason     = out_reason_r;
  assign out_alpha_longest_run = out_arun_r;
  assign out_beta_longest_run  = out_brun_r;

`ifndef SYNTHESIS
  // a waiting verdict must block new transactions
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while verdict stalled");

  // residue counter never runs past the expected total
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= expected_r))
    else $error("residue count beyond expected");

  // a beta-run reject really has a short beta run
  a_beta_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reason_r == RSN_BETA_RUN) |-> (out_brun_r < min_run_r))
    else $error("beta run reject with long enough run");

  // a fresh verdict clears the open match
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && command_t'(in_command) == CMD_RESIDUE && out_valid_nxt && !out_valid_r)
    |=> (expected_r == '0))
    else $error("match left open after verdict");
`endif

endmodule

`default_nettype wire

### tb/sv/cmfr_verdict_checker.sv
// Checker: follows both channels and the register port, predicts each verdict and compares.
`timescale 1ns / 1ps

module cmfr_verdict_checker #(
  parameter int unsigned MAX_PEP = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_command,
  input  logic [1:0]                     in_link_type,
  input  logic [cmfr_pkg::SiteW-1:0]     in_alpha_site,
  input  logic [cmfr_pkg::SiteW-1:0]     in_beta_site,
  input  logic [cmfr_pkg::LenW-1:0]      in_alpha_length,
  input  logic [cmfr_pkg::LenW-1:0]      in_beta_length,
  input  logic                           in_is_pair,
  input  logic [31:0]                    in_evalue,
  input  logic signed [31:0]             in_score,
  input  logic [31:0]                    in_matched_intensity,
  input  logic [31:0]                    in_unmatched_intensity,
  input  logic [7:0]                     in_residue_confidence,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_accepted,
  input  logic [2:0]                     out_reject_reason,
  input  logic [cmfr_pkg::LenW-1:0]      out_alpha_longest_run,
  input  logic [cmfr_pkg::LenW-1:0]      out_beta_longest_run,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cmfr_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int unsigned                    n_fail,
  output int unsigned                    n_pending
);
  import cmfr_pkg::*;

  typedef struct {
    logic            acc;
    reason_t         rsn;
    logic [LenW-1:0] a_run;
    logic [LenW-1:0] b_run;
  } verdict_t;

  verdict_t verdict_q[$];
  int unsigned fails = 0;

  // register copy
  logic [31:0]        ev_max;
  logic signed [31:0] sc_min;
  logic [LenW-1:0]    len_min;
  logic [15:0]        ratio_min;
  logic [7:0]         conf_lvl;
  logic [LenW-1:0]    run_min;
  logic               allow_ct;

  // open match
  reason_t           pend_rsn;
  logic [LenW-1:0]   alpha_len_q;
  logic              pair_q;
  logic [CountW-1:0] exp_res;
  logic [CountW-1:0] res_cnt;
  logic [LenW-1:0]   run_now;
  logic [LenW-1:0]   run_best;
  logic [LenW-1:0]   alpha_best;

  function automatic logic [LenW-1:0] clip_len(input logic [LenW-1:0] l);
    return (l > LenW'(MAX_PEP)) ? LenW'(MAX_PEP) : l;
  endfunction

  function automatic logic on_last_residue(input logic [SiteW-1:0] s,
                                           input logic [LenW-1:0]  l);
    return (l != '0) && ({1'b0, s} == l - LenW'(1));
  endfunction

  task automatic close_match();
    verdict_t v;
    v.rsn   = pend_rsn;
    v.a_run = alpha_best;
    v.b_run = pair_q ? run_best : '0;
    if (v.rsn == RSN_PASS && v.a_run < run_min) v.rsn = RSN_ALPHA_RUN;
    if (v.rsn == RSN_PASS && pair_q && v.b_run < run_min) v.rsn = RSN_BETA_RUN;
    v.acc = (v.rsn == RSN_PASS);
    verdict_q.push_back(v);
    exp_res = '0;
    res_cnt = '0;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t        want;
    reason_t         rsn;
    logic            hit;
    logic [LenW-1:0] alen;
    logic [LenW-1:0] blen;
    logic [63:0]     lhs;
    logic [63:0]     rhs;
    if (!rst_n) begin
      ev_max      = '1;
      sc_min      = 32'sh8000_0000;
      len_min     = '0;
      ratio_min   = '0;
      conf_lvl    = '0;
      run_min     = '0;
      allow_ct    = 1'b1;
      pend_rsn    = RSN_PASS;
      alpha_len_q = '0;
      pair_q      = 1'b0;
      exp_res     = '0;
      res_cnt     = '0;
      run_now     = '0;
      run_best    = '0;
      alpha_best  = '0;
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict with none expected: accepted %0d reason %0d",
                 out_accepted, out_reject_reason);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          cmp_field("accepted", 32'(want.acc), 32'(out_accepted));
          cmp_field("reject_reason", 32'(want.rsn), 32'(out_reject_reason));
          cmp_field("alpha_longest_run", 32'(want.a_run), 32'(out_alpha_longest_run));
          cmp_field("beta_longest_run", 32'(want.b_run), 32'(out_beta_longest_run));
        end
      end

      if (in_valid && in_ready) begin
        if (command_t'(in_command) == CMD_HEADER) begin
          alen = clip_len(in_alpha_length);
          blen = clip_len(in_beta_length);
          hit  = 1'b0;
          if (!allow_ct) begin
            case (link_type_t'(in_link_type))
              LINK_SINGLE: hit = on_last_residue(in_alpha_site, alen);
              LINK_LOOP:   hit = on_last_residue(in_alpha_site, alen) ||
                                 on_last_residue(in_beta_site, alen);
              LINK_PAIR:   hit = on_last_residue(in_alpha_site, alen) ||
                                 on_last_residue(in_beta_site, blen);
              default:     hit = 1'b0;
            endcase
          end
          lhs = {24'b0, in_matched_intensity, 8'b0};
          rhs = 64'(ratio_min) * 64'(in_unmatched_intensity);
          if (hit) rsn = RSN_CTERM;
          else if (in_evalue > ev_max) rsn = RSN_EVALUE;
          else if (in_score < sc_min) rsn = RSN_SCORE;
          else if (alen < len_min || (in_is_pair && blen < len_min)) rsn = RSN_LENGTH;
          else if (in_unmatched_intensity != '0 && lhs < rhs) rsn = RSN_RATIO;
          else rsn = RSN_PASS;
          pend_rsn    = rsn;
          alpha_len_q = alen;
          pair_q      = in_is_pair;
          exp_res     = CountW'(alen) + (in_is_pair ? CountW'(blen) : '0);
          res_cnt     = '0;
          run_now     = '0;
          run_best    = '0;
          alpha_best  = '0;
          if (exp_res == '0) close_match();
        end else if (exp_res != '0) begin
          if (in_residue_confidence >= conf_lvl) begin
            run_now = run_now + LenW'(1);
            if (run_now > run_best) run_best = run_now;
          end else begin
            run_now = '0;
          end
          res_cnt = res_cnt + CountW'(1);
          // alpha done: keep its run, beta starts afresh
          if (res_cnt == CountW'(alpha_len_q)) begin
            alpha_best = run_best;
            run_now    = '0;
            run_best   = '0;
          end
          if (res_cnt >= exp_res) close_match();
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[AddrW-1:2]))
          REG_EVALUE_MAX:  ev_max    = pwdata;
          REG_SCORE_MIN:   sc_min    = pwdata;
          REG_MIN_PEP_LEN: len_min   = pwdata[LenW-1:0];
          REG_RATIO_MIN:   ratio_min = pwdata[15:0];
          REG_CONF_LEVEL:  conf_lvl  = pwdata[7:0];
          REG_MIN_RUN:     run_min   = pwdata[LenW-1:0];
          REG_ALLOW_CTERM: allow_ct  = pwdata[0];
          default: ;
        endcase
      end
    end
    n_fail    <= fails;
    n_pending <= verdict_q.size();
  end

endmodule

### tb/sv/tb.sv
// Testbench top: clock, reset, stimulus, register programming and final verdict.
`timescale 1ns / 1ps

module tb;
  import cmfr_pkg::*;

  // Quiet cycles allowed before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 4096;
  localparam int unsigned PHASE_ITEMS  = 400;
  localparam int unsigned IDLE_PCT     = 26;
  // verdict is registered as its last input is taken, so a short pause covers it
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int          KEEP_ALL     = -1;
  localparam int          KEEP_SOME    = -2;
  localparam int          CONF_RANDOM  = -1;

  // One input transaction, header and residue fields together.
  typedef struct packed {
    command_t         cmd;
    link_type_t       link;
    logic [SiteW-1:0] a_site;
    logic [SiteW-1:0] b_site;
    logic [LenW-1:0]  a_len;
    logic [LenW-1:0]  b_len;
    logic             pair;
    logic [31:0]      evalue;
    logic [31:0]      score;
    logic [31:0]      matched;
    logic [31:0]      unmatched;
    logic [7:0]       conf;
  } xl_item_t;

  logic               clk;
  logic               rst_n                  = 1'b0;
  logic               in_valid               = 1'b0;
  logic               in_ready;
  logic               in_command             = 1'b0;
  logic [1:0]         in_link_type           = '0;
  logic [SiteW-1:0]   in_alpha_site          = '0;
  logic [SiteW-1:0]   in_beta_site           = '0;
  logic [LenW-1:0]    in_alpha_length        = '0;
  logic [LenW-1:0]    in_beta_length         = '0;
  logic               in_is_pair             = 1'b0;
  logic [31:0]        in_evalue              = '0;
  logic signed [31:0] in_score               = '0;
  logic [31:0]        in_matched_intensity   = '0;
  logic [31:0]        in_unmatched_intensity = '0;
  logic [7:0]         in_residue_confidence  = '0;
  logic               out_valid;
  logic               out_ready              = 1'b0;
  logic               out_accepted;
  logic [2:0]         out_reject_reason;
  logic [LenW-1:0]    out_alpha_longest_run;
  logic [LenW-1:0]    out_beta_longest_run;
  logic               psel                   = 1'b0;
  logic               penable                = 1'b0;
  logic               pwrite                 = 1'b0;
  logic [AddrW-1:0]   paddr                  = '0;
  logic [31:0]        pwdata                 = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned chk_fails;
  int unsigned chk_pending;
  int unsigned quiet_cycles = 0;
  int unsigned n_items      = 0;
  bit          idle_on      = 1'b1;

  // Copies of the programmed thresholds, used only to steer stimulus near edges.
  logic [31:0] ev_cfg   = '1;
  logic [31:0] sc_cfg   = 32'h8000_0000;
  logic [7:0]  conf_cfg = '0;

  crosslink_match_result_filter_unit u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_command             (in_command),
    .in_link_type           (in_link_type),
    .in_alpha_site          (in_alpha_site),
    .in_beta_site           (in_beta_site),
    .in_alpha_length        (in_alpha_length),
    .in_beta_length         (in_beta_length),
    .in_is_pair             (in_is_pair),
    .in_evalue              (in_evalue),
    .in_score               (in_score),
    .in_matched_intensity   (in_matched_intensity),
    .in_unmatched_intensity (in_unmatched_intensity),
    .in_residue_confidence  (in_residue_confidence),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_accepted           (out_accepted),
    .out_reject_reason      (out_reject_reason),
    .out_alpha_longest_run  (out_alpha_longest_run),
    .out_beta_longest_run   (out_beta_longest_run),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  cmfr_verdict_checker u_chk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_command             (in_command),
    .in_link_type           (in_link_type),
    .in_alpha_site          (in_alpha_site),
    .in_beta_site           (in_beta_site),
    .in_alpha_length        (in_alpha_length),
    .in_beta_length         (in_beta_length),
    .in_is_pair             (in_is_pair),
    .in_evalue              (in_evalue),
    .in_score               (in_score),
    .in_matched_intensity   (in_matched_intensity),
    .in_unmatched_intensity (in_unmatched_intensity),
    .in_residue_confidence  (in_residue_confidence),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_accepted           (out_accepted),
    .out_reject_reason      (out_reject_reason),
    .out_alpha_longest_run  (out_alpha_longest_run),
    .out_beta_longest_run   (out_beta_longest_run),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .pready                 (pready),
    .n_fail                 (chk_fails),
    .n_pending              (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure: random stalls unless idling is switched off.
  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Hang detector: any transaction on any port clears the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Residues actually expected for a peptide: long lengths clip at 64.
  function automatic int eff_len(input logic [LenW-1:0] l);
    return (l > LenW'(64)) ? 64 : int'(l);
  endfunction

  // Mostly short peptides, some mid-size, a few at or beyond the clip point.
  function automatic logic [LenW-1:0] pick_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return LenW'($urandom_range(127, 64));
    if (p < 13) return LenW'($urandom_range(63, 9));
    return LenW'($urandom_range(8, 0));
  endfunction

  // Every field random; callers overwrite what matters.
  function automatic xl_item_t rand_item();
    xl_item_t t;
    t.cmd       = command_t'($urandom_range(1));
    t.link      = link_type_t'($urandom_range(3));
    t.a_site    = SiteW'($urandom);
    t.b_site    = SiteW'($urandom);
    t.a_len     = LenW'($urandom);
    t.b_len     = LenW'($urandom);
    t.pair      = 1'($urandom);
    t.evalue    = $urandom;
    t.score     = $urandom;
    t.matched   = $urandom;
    t.unmatched = $urandom;
    t.conf      = 8'($urandom);
    return t;
  endfunction

  function automatic xl_item_t res_item(input logic [7:0] c);
    xl_item_t t;
    t      = rand_item();
    t.cmd  = CMD_RESIDUE;
    t.conf = c;
    return t;
  endfunction

  // A header that passes every header check, one alpha residue long.
  function automatic xl_item_t base_hdr();
    xl_item_t h;
    h           = rand_item();
    h.cmd       = CMD_HEADER;
    h.link      = LINK_NONE;
    h.a_site    = '0;
    h.b_site    = '0;
    h.a_len     = LenW'(1);
    h.b_len     = '0;
    h.pair      = 1'b0;
    h.evalue    = '0;
    h.score     = 32'd1;
    h.matched   = 32'd1;
    h.unmatched = '0;
    return h;
  endfunction

  // Random header biased towards the decision boundaries: sites on the last
  // residue, e-value and score around their thresholds, comparable intensities.
  function automatic xl_item_t rand_hdr();
    xl_item_t    h;
    int unsigned pick;
    h       = rand_item();
    h.cmd   = CMD_HEADER;
    h.a_len = pick_len();
    h.b_len = pick_len();
    if ($urandom_range(99) < 30) h.a_site = SiteW'(eff_len(h.a_len) - 1);
    if ($urandom_range(99) < 30)
      h.b_site = SiteW'(eff_len(h.link == LINK_LOOP ? h.a_len : h.b_len) - 1);
    pick = $urandom_range(99);
    if (pick < 45) h.evalue = $urandom_range(ev_cfg, 0);
    else if (pick < 60) h.evalue = ev_cfg + 32'($urandom_range(2)) - 32'd1;
    pick = $urandom_range(99);
    // unsigned difference is the true headroom above the signed minimum
    if (pick < 45) h.score = sc_cfg + $urandom_range(32'h7FFF_FFFF - sc_cfg, 0);
    else if (pick < 60) h.score = sc_cfg + 32'($urandom_range(2)) - 32'd1;
    pick = $urandom_range(99);
    if (pick < 20) begin
      h.unmatched = '0;
    end else if (pick < 60) begin
      h.matched   = $urandom_range(1023);
      h.unmatched = $urandom_range(1023, 1);
    end
    return h;
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic send_txn(input xl_item_t t);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid               <= 1'b1;
    in_command             <= t.cmd;
    in_link_type           <= t.link;
    in_alpha_site          <= t.a_site;
    in_beta_site           <= t.b_site;
    in_alpha_length        <= t.a_len;
    in_beta_length         <= t.b_len;
    in_is_pair             <= t.pair;
    in_evalue              <= t.evalue;
    in_score               <= t.score;
    in_matched_intensity   <= t.matched;
    in_unmatched_intensity <= t.unmatched;
    in_residue_confidence  <= t.conf;
    do @(posedge clk); while (!in_ready);
  endtask

  // Header then its residues. keep: all, a random short count (match left open,
  // later abandoned by the next header), or an exact number. conf: fixed or biased.
  task automatic send_match(input xl_item_t hdr, input int keep, input int conf);
    int         total;
    int         n;
    logic [7:0] c;
    total = eff_len(hdr.a_len) + (hdr.pair ? eff_len(hdr.b_len) : 0);
    if (keep == KEEP_ALL) n = total;
    else if (keep == KEEP_SOME) n = (total == 0) ? 0 : $urandom_range(total - 1, 0);
    else n = keep;
    send_txn(hdr);
    for (int i = 0; i < n; i++) begin
      if (conf < 0)
        c = ($urandom_range(99) < 65) ? 8'($urandom_range(255, conf_cfg))
                                      : 8'($urandom_range(conf_cfg, 0));
      else
        c = 8'(conf);
      send_txn(res_item(c));
    end
    n_items += 1 + n;
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] ev, input logic [31:0] sc,
                              input logic [LenW-1:0] len, input logic [15:0] ratio,
                              input logic [7:0] conf, input logic [LenW-1:0] run,
                              input logic allow);
    write_reg(REG_EVALUE_MAX, ev);
    write_reg(REG_SCORE_MIN, sc);
    write_reg(REG_MIN_PEP_LEN, 32'(len));
    write_reg(REG_RATIO_MIN, 32'(ratio));
    write_reg(REG_CONF_LEVEL, 32'(conf));
    write_reg(REG_MIN_RUN, 32'(run));
    write_reg(REG_ALLOW_CTERM, 32'(allow));
    ev_cfg   = ev;
    sc_cfg   = sc;
    conf_cfg = conf;
  endtask

  // Drop valid and wait for every predicted verdict, then a short pause so that
  // an abandoned or stray transaction has cleared the block too.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    xl_item_t    h;
    int unsigned kind;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: an empty match must pass with both runs at zero.
    h       = base_hdr();
    h.a_len = '0;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    settle();

    // Directed part. E-value limit 1.0, score limit 0, peptides of at least one
    // residue, ratio 1.0, confidence 128, run of one, C-terminal links refused.
    program_regs(32'h0100_0000, 32'h0, LenW'(1), 16'h0100, 8'd128, LenW'(1), 1'b0);

    // empty alpha, no beta: length reject straight off the header
    h       = base_hdr();
    h.a_len = '0;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // residue with no open match is dropped
    send_txn(res_item(8'd200));
    // single-site link on the last alpha residue; residues still consumed
    h      = base_hdr();
    h.link = LINK_SINGLE;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // loop link, second site on the last alpha residue
    h        = base_hdr();
    h.link   = LINK_LOOP;
    h.a_site = SiteW'(5);
    h.b_site = SiteW'(1);
    h.a_len  = LenW'(2);
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // alpha-beta link, beta site on the last beta residue
    h       = base_hdr();
    h.link  = LINK_PAIR;
    h.a_len = LenW'(2);
    h.b_len = LenW'(1);
    h.pair  = 1'b1;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // e-value saturated
    h        = base_hdr();
    h.evalue = '1;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // most negative score
    h       = base_hdr();
    h.score = 32'h8000_0000;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // intensity ratio far below 1.0
    h           = base_hdr();
    h.unmatched = '1;
    send_match(h, KEEP_ALL, CONF_RANDOM);
    // no confident alpha residue
    h = base_hdr();
    send_match(h, KEEP_ALL, 0);
    // alpha confident, beta just under the level
    h       = base_hdr();
    h.b_len = LenW'(1);
    h.pair  = 1'b1;
    send_match(h, 0, CONF_RANDOM);
    send_txn(res_item(8'd255));
    send_txn(res_item(8'd127));
    // match left open, abandoned by the next header
    send_match(h, 1, 255);
    // clean pass at the boundaries: e-value equal to limit, ratio exactly 1.0,
    // confidence equal to level, largest score, sites at 63
    h           = base_hdr();
    h.link      = LINK_PAIR;
    h.a_site    = '1;
    h.b_site    = '1;
    h.evalue    = 32'h0100_0000;
    h.score     = 32'h7FFF_FFFF;
    h.matched   = '1;
    h.unmatched = '1;
    send_match(h, KEEP_ALL, 128);
    settle();

    // Random phases: permissive extremes with no idling, random thresholds,
    // strict extremes, random thresholds again.
    for (int ph = 0; ph < 4; ph++) begin
      idle_on <= (ph != 0);
      case (ph)
        0: program_regs('1, 32'h8000_0000, '0, '0, '0, '0, 1'b1);
        2: program_regs('0, 32'h7FFF_FFFF, LenW'(64), 16'hFFFF, 8'hFF, LenW'(64), 1'b0);
        default: program_regs($urandom, $urandom, LenW'($urandom_range(6)),
                              16'($urandom_range(16'h0300)), 8'($urandom),
                              LenW'($urandom_range(4)), 1'($urandom_range(1)));
      endcase
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 8) repeat ($urandom_range(3, 1)) send_txn(res_item(8'($urandom)));
        else if (kind < 18) send_match(rand_hdr(), KEEP_SOME, CONF_RANDOM);
        else send_match(rand_hdr(), KEEP_ALL, CONF_RANDOM);
      end
      // close the phase on a finished match so that no match is open for the writes
      send_match(rand_hdr(), KEEP_ALL, CONF_RANDOM);
      settle();
    end

    if (chk_fails == 0 && chk_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
